>>> rtl/core/sfsa_pkg.sv
// ----------------------------------------------------------------------------
// sfsa_pkg
// Shared widths, codes and types of the sorted free-slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfsa_pkg;

  localparam int DATA_W    = 32;
  localparam int REQ_W     = 24;
  localparam int CFG_W     = 25;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_FREE_SLOTS  = 8;
  localparam int DEF_ALIGN_BYTES = 8;

  localparam logic [DATA_W-1:0] RST_REGION_BASE  = DATA_W'(65536);
  localparam logic [CFG_W-1:0]  RST_FIRST_CHUNK  = CFG_W'(4096);
  localparam logic [DATA_W-1:0] RST_SIZE_LIMIT   = '0;
  localparam logic [CFG_W-1:0]  RST_GROW_INCR    = CFG_W'(4096);

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd1;
  localparam logic [STAT_W-1:0] ST_DISCARD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHUNK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROW_INCR   = 2'd3;

  typedef enum logic [1:0] {
    TBL_NOP,
    TBL_INIT,
    TBL_INSERT,
    TBL_WRITE
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e             op;
    logic [DATA_W-1:0]   size;
    logic [DATA_W-1:0]   addr;
  } tbl_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALIGN,
    S_FREE_RND,
    S_FREE_SCAN,
    S_FREE_INS,
    S_SCAN,
    S_GROW_CHK,
    S_GROW_RND,
    S_TAKE,
    S_SORT,
    S_DONE
  } fsm_state_e;

endpackage

`default_nettype wire

>>> rtl/core/sfsa_rem_unit.sv
// ----------------------------------------------------------------------------
// sfsa_rem_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfsa_rem_unit #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVS_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             run_q;
  logic             done_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic [DVS_W-1:0] rem_step;

  always_comb begin
    trial    = {rem_q, dvd_q[DVD_W-1]};
    diff     = trial - {1'b0, dvs_q};
    rem_step = (trial >= {1'b0, dvs_q}) ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DVD_W);
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= rem_step;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> rtl/core/sfsa_table.sv
// ----------------------------------------------------------------------------
// sfsa_table
// Free region table: sizes and addresses with one read port, a single-entry
// write, an insert that shifts the tail down, and an init load.
// ----------------------------------------------------------------------------
`default_nettype none

module sfsa_table
  import sfsa_pkg::*;
#(
  parameter int FREE_SLOTS = DEF_FREE_SLOTS,
  parameter int IDX_W      = $clog2(FREE_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbl_cmd_t          cmd_i,
  input  logic [IDX_W-1:0]  pos_i,
  input  logic [IDX_W-1:0]  rd_idx_i,
  output logic [DATA_W-1:0] rd_size_o,
  output logic [DATA_W-1:0] rd_addr_o
);

  logic [DATA_W-1:0] sizes_q [FREE_SLOTS];
  logic [DATA_W-1:0] addrs_q [FREE_SLOTS];
  logic [DATA_W-1:0] sizes_d [FREE_SLOTS];
  logic [DATA_W-1:0] addrs_d [FREE_SLOTS];

  always_comb begin
    for (int i = 0; i < FREE_SLOTS; i++) begin
      sizes_d[i] = sizes_q[i];
      addrs_d[i] = addrs_q[i];
    end
    unique case (cmd_i.op)
      TBL_NOP: begin
      end
      TBL_INIT: begin
        for (int i = 1; i < FREE_SLOTS; i++) begin
          sizes_d[i] = '0;
          addrs_d[i] = '0;
        end
        sizes_d[0] = cmd_i.size;
        addrs_d[0] = cmd_i.addr;
      end
      TBL_INSERT: begin
        for (int i = 1; i < FREE_SLOTS; i++) begin
          if (IDX_W'(i) > pos_i) begin
            sizes_d[i] = sizes_q[i-1];
            addrs_d[i] = addrs_q[i-1];
          end
        end
        for (int i = 0; i < FREE_SLOTS; i++) begin
          if (IDX_W'(i) == pos_i) begin
            sizes_d[i] = cmd_i.size;
            addrs_d[i] = cmd_i.addr;
          end
        end
      end
      TBL_WRITE: begin
        for (int i = 0; i < FREE_SLOTS; i++) begin
          if (IDX_W'(i) == pos_i) begin
            sizes_d[i] = cmd_i.size;
            addrs_d[i] = cmd_i.addr;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FREE_SLOTS; i++) begin
        sizes_q[i] <= '0;
        addrs_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < FREE_SLOTS; i++) begin
        sizes_q[i] <= sizes_d[i];
        addrs_q[i] <= addrs_d[i];
      end
    end
  end

  always_comb begin
    rd_size_o = '0;
    rd_addr_o = '0;
    if (int'(rd_idx_i) < FREE_SLOTS) begin
      rd_size_o = sizes_q[rd_idx_i];
      rd_addr_o = addrs_q[rd_idx_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sorted_free_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// sorted_free_slot_allocator_top
// Best-fit allocator over a sorted table of free regions, run by a small
// sequencer around one shared remainder unit.
// ----------------------------------------------------------------------------
//   channel   | handshake           | payload
//   ----------+---------------------+-------------------------------------------
//   command   | start, busy         | kind_i, request_size_i, block_address_i
//   result    | done_o (strobe)     | status_o, granted_address_o
//   config    | cfg_we_i, cfg_idx_i | cfg_wdata_i
//
// A command beat is taken when start is high and busy is low; busy then stays
// high up to and including the result strobe, and the next beat can be taken
// in the cycle after it. An allocate that grows the table also runs the shared
// unit for the increment remainder, and an alignment that is not a power of
// two runs it for each alignment remainder.
// The result beat lasts one cycle and cannot be stalled.
// Reset clears the table, the totals and the configuration to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_free_slot_allocator_top
  import sfsa_pkg::*;
#(
  parameter int FREE_SLOTS  = DEF_FREE_SLOTS,
  parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [REQ_W-1:0]     request_size_i,
  input  logic [DATA_W-1:0]    block_address_i,
  output logic                 done_o,
  output logic [STAT_W-1:0]    status_o,
  output logic [DATA_W-1:0]    granted_address_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i
);

  localparam int IDX_W = $clog2(FREE_SLOTS);
  localparam int CNT_W = $clog2(FREE_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(FREE_SLOTS);
  localparam logic [CFG_W-1:0] ALIGN_C = CFG_W'(ALIGN_BYTES);
  localparam bit ALIGN_POW2 = ((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0);
  localparam logic [DATA_W-1:0] ALIGN_D    = DATA_W'(ALIGN_BYTES);
  localparam logic [DATA_W-1:0] ALIGN_MASK = DATA_W'(ALIGN_BYTES - 1);

  fsm_state_e state_q, state_d;

  logic [DATA_W-1:0] base_q;
  logic [CFG_W-1:0]  fcs_q;
  logic [DATA_W-1:0] lim_q;
  logic [CFG_W-1:0]  gi_q;

  logic [DATA_W-1:0] tr_q, tr_d;
  logic [DATA_W-1:0] nf_q, nf_d;

  logic [KIND_W-1:0] kind_q, kind_d;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [DATA_W-1:0] addr_q, addr_d;
  logic [DATA_W-1:0] size_q, size_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] raddr_q, raddr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              found_q, found_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [DATA_W-1:0] gaddr_q, gaddr_d;

  tbl_cmd_t          tbl_cmd;
  logic [IDX_W-1:0]  tbl_pos;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] rd_size;
  logic [DATA_W-1:0] rd_addr;

  logic              mod_start;
  logic [DATA_W-1:0] mod_dvd;
  logic [CFG_W-1:0]  mod_dvs;
  logic              mod_done;
  logic [CFG_W-1:0]  mod_rem;

  logic [DATA_W-1:0] al_src;
  logic [DATA_W-1:0] al_rem;
  logic              al_rdy;
  logic [DATA_W-1:0] pad_al;
  logic [DATA_W-1:0] pad_gi;
  logic [DATA_W-1:0] chunk;
  logic [DATA_W:0]   tr_sum;
  logic [DATA_W-1:0] room;
  logic [DATA_W-1:0] free_sz;
  logic [DATA_W-1:0] take_rem;
  logic              accept;
  logic              scan_hit;
  logic              sort_hit;
  logic              fscan_hit;
  logic              free_bad;
  logic              grow_ok;

  sfsa_rem_unit #(
    .DVD_W (DATA_W),
    .DVS_W (CFG_W)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (mod_dvs),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  sfsa_table #(
    .FREE_SLOTS (FREE_SLOTS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tbl_cmd),
    .pos_i     (tbl_pos),
    .rd_idx_i  (rd_idx),
    .rd_size_o (rd_size),
    .rd_addr_o (rd_addr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= RST_REGION_BASE;
      fcs_q  <= RST_FIRST_CHUNK;
      lim_q  <= RST_SIZE_LIMIT;
      gi_q   <= RST_GROW_INCR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REGION_BASE: base_q <= cfg_wdata_i;
        REG_FIRST_CHUNK: fcs_q  <= cfg_wdata_i[CFG_W-1:0];
        REG_SIZE_LIMIT:  lim_q  <= cfg_wdata_i;
        REG_GROW_INCR:   gi_q   <= cfg_wdata_i[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept    = start && !busy;
  assign al_src    = (state_q == S_FREE_RND) ? size_q :
                     ((kind_q == KIND_ALLOC) ? DATA_W'(req_q) : addr_q);
  assign al_rem    = ALIGN_POW2 ? (al_src & ALIGN_MASK) : DATA_W'(mod_rem);
  assign al_rdy    = ALIGN_POW2 || mod_done;
  assign pad_al    = (al_rem == '0) ? '0 : ALIGN_D - al_rem;
  assign pad_gi    = (mod_rem == '0) ? '0 : DATA_W'(gi_q - mod_rem);
  assign chunk     = size_q + pad_gi;
  assign tr_sum    = {1'b0, tr_q} + {1'b0, chunk};
  assign room      = (tr_q > lim_q) ? '0 : lim_q - tr_q;
  assign free_sz   = size_q - al_rem;
  assign take_rem  = rd_size - size_q;
  assign free_bad  = (pad_al != '0) && (pad_al >= DATA_W'(req_q));
  assign scan_hit  = (cnt_q < SLOTS_C) && (rd_size >= size_q);
  assign sort_hit  = (cnt_q < SLOTS_C) && (rd_size > rem_q);
  assign fscan_hit = size_q > rd_size;
  assign grow_ok   = (gi_q != '0) && !((lim_q != '0) && (size_q > room));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_ALLOC || kind_i == KIND_FREE) begin
            state_d = S_ALIGN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ALIGN: begin
        if (al_rdy) begin
          if (kind_q == KIND_ALLOC) begin
            state_d = S_SCAN;
          end else if (free_bad) begin
            state_d = S_DONE;
          end else begin
            state_d = S_FREE_RND;
          end
        end
      end
      S_FREE_RND: begin
        if (al_rdy) begin
          state_d = (free_sz == '0) ? S_DONE : S_FREE_SCAN;
        end
      end
      S_FREE_SCAN: begin
        if (fscan_hit) begin
          if (cnt_q == '0) begin
            state_d = S_FREE_INS;
          end
        end else begin
          state_d = found_q ? S_FREE_INS : S_DONE;
        end
      end
      S_FREE_INS: state_d = S_DONE;
      S_SCAN: begin
        if (!scan_hit) begin
          state_d = (cnt_q == '0) ? S_GROW_CHK : S_TAKE;
        end
      end
      S_GROW_CHK: state_d = grow_ok ? S_GROW_RND : S_DONE;
      S_GROW_RND: begin
        if (mod_done) begin
          state_d = S_TAKE;
        end
      end
      S_TAKE: state_d = S_SORT;
      S_SORT: begin
        if (!sort_hit) begin
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    kind_d    = kind_q;
    req_d     = req_q;
    addr_d    = addr_q;
    size_d    = size_q;
    rem_d     = rem_q;
    raddr_d   = raddr_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    found_d   = found_q;
    status_d  = status_q;
    gaddr_d   = gaddr_q;
    tr_d      = tr_q;
    nf_d      = nf_q;
    mod_start = 1'b0;
    mod_dvd   = DATA_W'(req_q);
    mod_dvs   = ALIGN_C;
    tbl_cmd   = '{op: TBL_NOP, size: rem_q, addr: raddr_q};
    tbl_pos   = IDX_W'(cnt_q - CNT_W'(1));
    rd_idx    = cnt_q[IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d   = kind_i;
          req_d    = request_size_i;
          addr_d   = block_address_i;
          status_d = ST_DONE;
          gaddr_d  = '0;
          if (kind_i == KIND_ALLOC) begin
            mod_start = !ALIGN_POW2;
            mod_dvd   = DATA_W'(request_size_i);
          end else if (kind_i == KIND_FREE) begin
            mod_start = !ALIGN_POW2;
            mod_dvd   = block_address_i;
          end else if (kind_i == KIND_INIT) begin
            tbl_cmd = '{op: TBL_INIT, size: DATA_W'(fcs_q), addr: base_q};
            tr_d    = DATA_W'(fcs_q);
            nf_d    = base_q + DATA_W'(fcs_q);
          end
        end
      end
      S_ALIGN: begin
        if (al_rdy) begin
          if (kind_q == KIND_ALLOC) begin
            size_d = DATA_W'(req_q) + pad_al;
            cnt_d  = '0;
          end else if (free_bad) begin
            status_d = ST_DISCARD;
          end else begin
            addr_d    = addr_q + pad_al;
            size_d    = DATA_W'(req_q) - pad_al;
            mod_start = !ALIGN_POW2;
            mod_dvd   = DATA_W'(req_q) - pad_al;
          end
        end
      end
      S_FREE_RND: begin
        if (al_rdy) begin
          size_d  = free_sz;
          cnt_d   = CNT_W'(FREE_SLOTS - 1);
          found_d = 1'b0;
          if (free_sz == '0) begin
            status_d = ST_DISCARD;
          end
        end
      end
      S_FREE_SCAN: begin
        if (fscan_hit) begin
          idx_d   = cnt_q[IDX_W-1:0];
          found_d = 1'b1;
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end else if (!found_q) begin
          status_d = ST_DISCARD;
        end
      end
      S_FREE_INS: begin
        tbl_cmd = '{op: TBL_INSERT, size: size_q, addr: addr_q};
        tbl_pos = idx_q;
      end
      S_SCAN: begin
        if (scan_hit) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else if (cnt_q != '0) begin
          idx_d = IDX_W'(cnt_q - CNT_W'(1));
        end
      end
      S_GROW_CHK: begin
        if (grow_ok) begin
          mod_start = 1'b1;
          mod_dvd   = size_q;
          mod_dvs   = gi_q;
        end else begin
          status_d = ST_NOMEM;
        end
      end
      S_GROW_RND: begin
        if (mod_done) begin
          tbl_cmd = '{op: TBL_INSERT, size: chunk, addr: nf_q};
          tbl_pos = '0;
          nf_d    = nf_q + chunk;
          tr_d    = tr_sum[DATA_W] ? '1 : tr_sum[DATA_W-1:0];
          idx_d   = '0;
        end
      end
      S_TAKE: begin
        rd_idx  = idx_q;
        gaddr_d = rd_addr;
        rem_d   = take_rem;
        raddr_d = (take_rem == '0) ? '0 : rd_addr + size_q;
        cnt_d   = CNT_W'(idx_q) + CNT_W'(1);
      end
      S_SORT: begin
        if (sort_hit) begin
          tbl_cmd = '{op: TBL_WRITE, size: rd_size, addr: rd_addr};
          cnt_d   = cnt_q + CNT_W'(1);
        end else begin
          tbl_cmd = '{op: TBL_WRITE, size: rem_q, addr: raddr_q};
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tr_q     <= '0;
      nf_q     <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      kind_q   <= KIND_ALLOC;
      status_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      tr_q     <= tr_d;
      nf_q     <= nf_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      found_q  <= found_d;
      kind_q   <= kind_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    addr_q  <= addr_d;
    size_q  <= size_d;
    rem_q   <= rem_d;
    raddr_q <= raddr_d;
    gaddr_q <= gaddr_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = (state_q == S_DONE);
  assign status_o          = status_q;
  assign granted_address_o = gaddr_q;

  a_strobe_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a busy period");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe not followed by idle");

  a_fail_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_DONE) |-> (granted_address_o == '0))
    else $error("failed beat carries a nonzero address");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted free-slot allocator. A queue of command
// beats, directed first and then random in several configuration phases,
// feeds a clocked driver. A clocked monitor keeps a shadow copy of the free
// table and predicts the status and address of every command beat. Each
// result beat is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfsa_pkg::*;

  localparam int SLOTS           = DEF_FREE_SLOTS;
  localparam int ALIGN           = DEF_ALIGN_BYTES;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int SETTLE_CYCLES   = 120;
  localparam int MAX_REPORTS     = 10;
  localparam int MAX_LIVE        = 64;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [REQ_W-1:0]  size;
    logic [DATA_W-1:0] addr;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] addr;
  } grant_t;

  typedef struct packed {
    logic [DATA_W-1:0] addr;
    logic [REQ_W-1:0]  size;
  } block_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 start           = 1'b0;
  logic                 busy;
  logic [KIND_W-1:0]    kind_i          = '0;
  logic [REQ_W-1:0]     request_size_i  = '0;
  logic [DATA_W-1:0]    block_address_i = '0;
  logic                 done_o;
  logic [STAT_W-1:0]    status_o;
  logic [DATA_W-1:0]    granted_address_o;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [DATA_W-1:0]    cfg_wdata_i     = '0;

  logic [DATA_W-1:0] cfg_base  = RST_REGION_BASE;
  logic [CFG_W-1:0]  cfg_chunk = RST_FIRST_CHUNK;
  logic [DATA_W-1:0] cfg_limit = RST_SIZE_LIMIT;
  logic [CFG_W-1:0]  cfg_incr  = RST_GROW_INCR;

  logic [DATA_W-1:0] slot_size [SLOTS];
  logic [DATA_W-1:0] slot_addr [SLOTS];
  logic [DATA_W-1:0] rsv_total = '0;
  logic [DATA_W-1:0] fresh_ptr = '0;

  request_t request_q[$];
  grant_t   pending_grants[$];
  block_t   live_blocks[$];

  request_t cur_req;
  grant_t   exp_grant;
  grant_t   new_grant;
  block_t   new_block;
  bit       cmd_taken   = 1'b0;
  bit       activity;
  int       gap_left    = 0;
  int       calm_left   = 0;
  int       idle_cycles = 0;
  int       fail_count  = 0;
  int       k;

  sorted_free_slot_allocator_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .request_size_i    (request_size_i),
    .block_address_i   (block_address_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [63:0] round_to(logic [63:0] v, logic [63:0] m);
    if (m == 0) return v;
    return ((v + m - 1) / m) * m;
  endfunction

  function automatic void shift_slots_down(int pos);
    for (int i = SLOTS - 1; i > pos; i--) begin
      slot_size[i] = slot_size[i-1];
      slot_addr[i] = slot_addr[i-1];
    end
  endfunction

  function automatic grant_t predict_grant(logic [KIND_W-1:0] kind, logic [REQ_W-1:0] req,
                                           logic [DATA_W-1:0] addr);
    grant_t            g;
    logic [DATA_W-1:0] need;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] chunk;
    logic [DATA_W-1:0] room;
    logic [63:0]       up;
    logic [63:0]       trimmed;
    logic [63:0]       sum;
    int                hit;
    int                i;
    g.status = ST_DONE;
    g.addr   = '0;
    case (kind)
      KIND_ALLOC: begin
        need = 32'(round_to(64'(req), 64'(ALIGN)));
        hit  = -1;
        for (i = 0; i < SLOTS; i++) begin
          if (slot_size[i] >= need) hit = i;
          else break;
        end
        if (hit < 0) begin
          if (cfg_incr == 0) begin
            g.status = ST_NOMEM;
          end else if (cfg_limit != 0) begin
            room = (rsv_total > cfg_limit) ? '0 : cfg_limit - rsv_total;
            if (need > room) g.status = ST_NOMEM;
          end
          if (g.status == ST_DONE) begin
            chunk = 32'(round_to(64'(need), 64'(cfg_incr)));
            shift_slots_down(0);
            slot_size[0] = chunk;
            slot_addr[0] = fresh_ptr;
            fresh_ptr    = fresh_ptr + chunk;
            sum          = 64'(rsv_total) + 64'(chunk);
            rsv_total    = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
            hit          = 0;
          end
        end
        if (g.status == ST_DONE) begin
          g.addr = slot_addr[hit];
          rem    = slot_size[hit] - need;
          for (i = hit + 1; i < SLOTS; i++) begin
            if (slot_size[i] > rem) begin
              slot_size[i-1] = slot_size[i];
              slot_addr[i-1] = slot_addr[i];
            end else begin
              break;
            end
          end
          slot_size[i-1] = rem;
          slot_addr[i-1] = (rem == 0) ? '0 : g.addr + need;
        end
      end
      KIND_FREE: begin
        up      = round_to(64'(addr), 64'(ALIGN));
        trimmed = 64'(req);
        if (up - 64'(addr) >= trimmed) begin
          g.status = ST_DISCARD;
        end else begin
          trimmed = ((trimmed - (up - 64'(addr))) / 64'(ALIGN)) * 64'(ALIGN);
          hit     = -1;
          for (i = SLOTS - 1; i >= 0; i--) begin
            if (trimmed > 64'(slot_size[i])) hit = i;
            else break;
          end
          if (trimmed == 0 || hit < 0) begin
            g.status = ST_DISCARD;
          end else begin
            shift_slots_down(hit);
            slot_size[hit] = trimmed[31:0];
            slot_addr[hit] = up[31:0];
          end
        end
      end
      KIND_INIT: begin
        for (i = 0; i < SLOTS; i++) begin
          slot_size[i] = '0;
          slot_addr[i] = '0;
        end
        slot_size[0] = 32'(cfg_chunk);
        slot_addr[0] = cfg_base;
        rsv_total    = 32'(cfg_chunk);
        fresh_ptr    = cfg_base + 32'(cfg_chunk);
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 25);
    return $urandom_range(40, 150);
  endfunction

  task automatic queue_request(logic [KIND_W-1:0] kind, logic [REQ_W-1:0] size,
                               logic [DATA_W-1:0] addr);
    request_t req;
    req.kind = kind;
    req.size = size;
    req.addr = addr;
    request_q.push_back(req);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (request_q.size() != 0 || start || pending_grants.size() != 0 || busy);
  endtask

  task automatic run_phase(logic [DATA_W-1:0] base, logic [CFG_W-1:0] chunk,
                           logic [DATA_W-1:0] limit, logic [CFG_W-1:0] incr, int count);
    request_t req;
    block_t   blk;
    int       r;
    int       pick;
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_REGION_BASE;
    cfg_wdata_i <= base;
    @(negedge clk_i);
    cfg_idx_i   <= REG_FIRST_CHUNK;
    cfg_wdata_i <= 32'(chunk);
    @(negedge clk_i);
    cfg_idx_i   <= REG_SIZE_LIMIT;
    cfg_wdata_i <= limit;
    @(negedge clk_i);
    cfg_idx_i   <= REG_GROW_INCR;
    cfg_wdata_i <= 32'(incr);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    live_blocks.delete();
    queue_request(KIND_INIT, REQ_W'($urandom), $urandom);
    for (int n = 0; n < count; n++) begin
      while (request_q.size() > 1) @(negedge clk_i);
      r        = $urandom_range(0, 99);
      req.addr = $urandom;
      req.size = REQ_W'($urandom);
      if (r < 3) begin
        req.kind = KIND_INIT;
      end else if (r < 6) begin
        req.kind = KIND_UNUSED;
      end else if (r < 52) begin
        req.kind = KIND_ALLOC;
        r = $urandom_range(0, 99);
        if (r < 70) req.size = REQ_W'($urandom_range(0, 300));
        else if (r < 90) req.size = REQ_W'($urandom_range(0, 70000));
      end else begin
        req.kind = KIND_FREE;
        if (live_blocks.size() > 0 && $urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, live_blocks.size() - 1);
          blk  = live_blocks[pick];
          live_blocks.delete(pick);
          req.addr = blk.addr;
          req.size = blk.size;
          if ($urandom_range(0, 4) == 0) req.addr = req.addr + $urandom_range(1, 7);
          if ($urandom_range(0, 4) == 0) req.size = req.size + REQ_W'($urandom_range(0, 16));
        end else if ($urandom_range(0, 1) == 0) begin
          req.addr = cfg_base + $urandom_range(0, 65535);
          req.size = REQ_W'($urandom_range(0, 2000));
        end
      end
      request_q.push_back(req);
    end
  endtask

  // A new command beat goes out once the previous one was taken and its gap
  // has run out; start stays high across back-to-back beats.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      if (cmd_taken) begin
        cmd_taken = 1'b0;
        gap_left  = pick_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_q.size() > 0) begin
        cur_req = request_q.pop_front();
        kind_i          <= cur_req.kind;
        request_size_i  <= cur_req.size;
        block_address_i <= cur_req.addr;
        start           <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      activity = 1'b0;
      if (cfg_we_i) begin
        activity = 1'b1;
        case (cfg_idx_i)
          REG_REGION_BASE: cfg_base  = cfg_wdata_i;
          REG_FIRST_CHUNK: cfg_chunk = cfg_wdata_i[CFG_W-1:0];
          REG_SIZE_LIMIT:  cfg_limit = cfg_wdata_i;
          REG_GROW_INCR:   cfg_incr  = cfg_wdata_i[CFG_W-1:0];
          default: begin
          end
        endcase
      end
      if (done_o) begin
        activity = 1'b1;
        if (pending_grants.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result beat: status %0d address %h",
                     status_o, granted_address_o);
        end else begin
          exp_grant = pending_grants.pop_front();
          if (status_o !== exp_grant.status || granted_address_o !== exp_grant.addr) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: status exp %0d got %0d, address exp %h got %h",
                       exp_grant.status, status_o, exp_grant.addr, granted_address_o);
          end
        end
      end
      if (start && !busy) begin
        activity  = 1'b1;
        cmd_taken = 1'b1;
        new_grant = predict_grant(kind_i, request_size_i, block_address_i);
        pending_grants.push_back(new_grant);
        if (kind_i == KIND_ALLOC && new_grant.status == ST_DONE && request_size_i != 0 &&
            live_blocks.size() < MAX_LIVE) begin
          new_block.addr = new_grant.addr;
          new_block.size = request_size_i;
          live_blocks.push_back(new_block);
        end
      end
      idle_cycles = activity ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_size[i] = '0;
      slot_addr[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_request(KIND_ALLOC, 24'd100, '0);
    queue_request(KIND_ALLOC, 24'd0, '1);
    queue_request(KIND_INIT, '0, '0);
    queue_request(KIND_ALLOC, 24'd0, '0);
    queue_request(KIND_ALLOC, 24'd1, '0);
    queue_request(KIND_ALLOC, 24'hFF_FFFF, '0);
    queue_request(KIND_FREE, 24'd5, 32'd3);
    queue_request(KIND_FREE, 24'd7, 32'h0000_0100);
    queue_request(KIND_FREE, 24'd100, 32'h0000_0201);
    queue_request(KIND_FREE, 24'hFF_FFFF, 32'hFFFF_FFFF);
    queue_request(KIND_UNUSED, '1, '1);
    for (k = 0; k < 9; k++) queue_request(KIND_FREE, 24'd16, 32'h0002_0000 + 32'(32 * k));
    queue_request(KIND_FREE, 24'd8, 32'h0003_0000);
    queue_request(KIND_ALLOC, 24'd16, '0);
    queue_request(KIND_UNUSED, '0, '0);

    run_phase(RST_REGION_BASE, RST_FIRST_CHUNK, RST_SIZE_LIMIT, RST_GROW_INCR, 140);
    run_phase(32'hFFFF_F000, 25'h100_0000, 32'hFFFF_FFFF, 25'd1, 110);
    run_phase(32'h0000_0000, 25'd8, 32'd20000, 25'd4096, 110);
    run_phase(32'h1234_5677, 25'd1000, 32'd500, 25'd24, 110);
    run_phase(32'h8000_0000, 25'd65536, 32'd0, 25'd0, 110);
    run_phase($urandom, CFG_W'($urandom_range(8, 8192)), 32'($urandom_range(0, 300000)),
              25'h100_0000, 110);
    run_phase($urandom, CFG_W'($urandom_range(8, 32'h100_0000)), $urandom,
              CFG_W'($urandom_range(1, 8192)), 110);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
